### src/directed_cycle_finder_assert.svh
// ----------------------------------------------------------------------------
// directed cycle finder assertion macros
// concurrent checks sampled on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DIRECTED_CYCLE_FINDER_ASSERT_SVH
`define DIRECTED_CYCLE_FINDER_ASSERT_SVH

// same-cycle implication
`define DCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_pkg
// shared widths, vertex count constants and command codes of the directed cycle finder
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int unsigned VW  = 6;        // vertex id width
  localparam int unsigned NV  = 64;       // vertex slots
  localparam int unsigned SPW = 7;        // stack pointer, holds NV
  localparam int unsigned CW  = 2;        // command width
  localparam int unsigned VCW = 7;        // vertex_count width

  localparam logic [VCW-1:0] VC_RESET = 7'd64;
  localparam logic [VCW-1:0] VC_MAX   = 7'd64;

  localparam logic [CW-1:0] CMD_ADD   = 2'd0;
  localparam logic [CW-1:0] CMD_RUN   = 2'd1;
  localparam logic [CW-1:0] CMD_CLEAR = 2'd2;

endpackage

### src/directed_cycle_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directed_cycle_finder
// depth-first directed cycle search over edges kept in ram linked lists
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o    cmd_i, from_vertex_i, to_vertex_i
// out      out  out_valid_o / out_stall_i  vertex_o, valid_res_o, cycle_end_o,
//                                          last_o, truncated_o, edges_dropped_o
// cfg      in   cfg_we_i                   cfg_data_i (vertex_count)
//
// add edge: one state, plus the relink state when the list already has a tail
// clear: list heads drop through one valid bit per vertex
// run: edge visits, push, pop and root steps, emitted vertices and parent
//   links walked each wait on a read of the simple dual port rams, whose
//   registered read sets this pace
// reset gives empty lists and vertex_count 64, no clearing pass
// out stall holds the engine only when the output and pending slots are full,
//   or at the final item while the output register is full
// ----------------------------------------------------------------------------
`include "directed_cycle_finder_assert.svh"

module directed_cycle_finder #(
  parameter int unsigned MAX_EDGES = 256,
  parameter int unsigned OUT_LIMIT = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dcf_pkg::VCW-1:0]   cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dcf_pkg::CW-1:0]    cmd_i,
  input  logic [dcf_pkg::VW-1:0]    from_vertex_i,
  input  logic [dcf_pkg::VW-1:0]    to_vertex_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dcf_pkg::VW-1:0]    vertex_o,
  output logic                      valid_res_o,
  output logic                      cycle_end_o,
  output logic                      last_o,
  output logic                      truncated_o,
  output logic                      edges_dropped_o
);

  localparam int unsigned EW = $clog2(MAX_EDGES);       // edge index width
  localparam int unsigned LW = EW + 1;                  // link width, with null
  localparam int unsigned OW = $clog2(OUT_LIMIT + 1);   // emitted count width
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);
  localparam int unsigned VW = dcf_pkg::VW;
  localparam int unsigned NV = dcf_pkg::NV;
  localparam int unsigned SW = VW + LW;                 // stack entry width

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD2 = 4'd1;   // relink old tail
  localparam logic [3:0] S_ROOT = 4'd2;   // pick next root
  localparam logic [3:0] S_HEAD = 4'd3;   // head read returns
  localparam logic [3:0] S_STEP = 4'd4;   // look at top of stack
  localparam logic [3:0] S_POP  = 4'd5;   // stack read returns
  localparam logic [3:0] S_EDGE = 4'd6;   // edge read returns
  localparam logic [3:0] S_WALK = 4'd7;   // parent read returns
  localparam logic [3:0] S_ERD  = 4'd8;   // read cycle buffer
  localparam logic [3:0] S_EMIT = 4'd9;   // cycle buffer data returns
  localparam logic [3:0] S_FIN  = 4'd10;  // final result

  logic [3:0]              state_q, state_d;
  logic [dcf_pkg::VCW-1:0] vc_q;
  logic [dcf_pkg::VCW-1:0] lim;
  logic [LW-1:0]           used_q, used_d;
  logic                    drop_q, drop_d;
  logic [NV-1:0]           hvalid_q, hvalid_d;    // list nonempty
  logic [NV-1:0]           visited_q, visited_d;
  logic [NV-1:0]           on_path_q, on_path_d;
  logic                    hv_rd_q, hv_rd_d;      // valid bit of the head read
  logic [LW-1:0]           idx_q, idx_d;
  logic [dcf_pkg::VCW-1:0] root_q, root_d;
  logic [dcf_pkg::SPW-1:0] sp_q, sp_d;            // entries incl. the top
  logic [VW-1:0]           top_v_q, top_v_d;
  logic [LW-1:0]           top_e_q, top_e_d;
  logic [VW-1:0]           cyc_w_q, cyc_w_d;
  logic [dcf_pkg::SPW-1:0] n_q, n_d;              // cycle buffer fill
  logic [OW-1:0]           emit_cnt_q, emit_cnt_d;
  logic                    trunc_q, trunc_d;
  logic                    pend_v_q, pend_v_d;    // held result, last unknown yet
  logic [VW-1:0]           pend_vtx_q, pend_vtx_d;
  logic                    pend_end_q, pend_end_d;
  logic                    out_valid_q, out_valid_d;
  logic [VW-1:0]           out_vtx_q, out_vtx_d;
  logic                    out_res_q, out_res_d;
  logic                    out_end_q, out_end_d;
  logic                    out_last_q, out_last_d;
  logic                    out_trunc_q, out_trunc_d;
  logic                    out_drop_q, out_drop_d;
  logic                    out_free, slot_free;

  // ram ports
  logic          tgt_we, tgt_re;
  logic [EW-1:0] tgt_waddr, tgt_raddr;
  logic [VW-1:0] tgt_wdata, tgt_rdata;
  logic          nxt_we, nxt_re;
  logic [EW-1:0] nxt_waddr, nxt_raddr;
  logic [LW-1:0] nxt_wdata, nxt_rdata;
  logic          head_we, head_re;
  logic [VW-1:0] head_waddr, head_raddr;
  logic [LW-1:0] head_wdata, head_rdata;
  logic          tail_we, tail_re;
  logic [VW-1:0] tail_waddr, tail_raddr;
  logic [LW-1:0] tail_wdata, tail_rdata;
  logic          par_we, par_re;
  logic [VW-1:0] par_waddr, par_raddr;
  logic [VW-1:0] par_wdata, par_rdata;
  logic          stk_we, stk_re;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic          buf_we, buf_re;
  logic [VW-1:0] buf_waddr, buf_raddr;
  logic [VW-1:0] buf_wdata, buf_rdata;

  logic [VW-1:0]           w;
  logic [dcf_pkg::SPW-1:0] sp_m1, sp_m2, n_m1;

  assign lim   = (vc_q > dcf_pkg::VC_MAX) ? dcf_pkg::VC_MAX : vc_q;
  assign w     = tgt_rdata;
  assign sp_m1 = sp_q - 1'b1;
  assign sp_m2 = sp_q - 2'd2;
  assign n_m1  = n_q - 1'b1;

  // edge store, list ends and search state rams
  dcf_ram #(.DEPTH(MAX_EDGES), .WIDTH(VW)) u_tgt (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(tgt_wdata),
    .re_i(tgt_re), .raddr_i(tgt_raddr), .rdata_o(tgt_rdata));
  dcf_ram #(.DEPTH(MAX_EDGES), .WIDTH(LW)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .re_i(nxt_re), .raddr_i(nxt_raddr), .rdata_o(nxt_rdata));
  dcf_ram #(.DEPTH(NV), .WIDTH(LW)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata));
  dcf_ram #(.DEPTH(NV), .WIDTH(LW)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_waddr), .wdata_i(tail_wdata),
    .re_i(tail_re), .raddr_i(tail_raddr), .rdata_o(tail_rdata));
  dcf_ram #(.DEPTH(NV), .WIDTH(VW)) u_par (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .re_i(par_re), .raddr_i(par_raddr), .rdata_o(par_rdata));
  dcf_ram #(.DEPTH(NV), .WIDTH(SW)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata));
  dcf_ram #(.DEPTH(NV), .WIDTH(VW)) u_buf (
    .clk_i, .we_i(buf_we), .waddr_i(buf_waddr), .wdata_i(buf_wdata),
    .re_i(buf_re), .raddr_i(buf_raddr), .rdata_o(buf_rdata));

  // output register frees when taken; pending slot moves up behind it
  assign out_free  = !out_valid_q || !out_stall_i;
  assign slot_free = !pend_v_q || out_free;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    drop_d      = drop_q;
    hvalid_d    = hvalid_q;
    visited_d   = visited_q;
    on_path_d   = on_path_q;
    hv_rd_d     = hv_rd_q;
    idx_d       = idx_q;
    root_d      = root_q;
    sp_d        = sp_q;
    top_v_d     = top_v_q;
    top_e_d     = top_e_q;
    cyc_w_d     = cyc_w_q;
    n_d         = n_q;
    emit_cnt_d  = emit_cnt_q;
    trunc_d     = trunc_q;
    pend_v_d    = pend_v_q;
    pend_vtx_d  = pend_vtx_q;
    pend_end_d  = pend_end_q;
    out_valid_d = out_valid_q;
    out_vtx_d   = out_vtx_q;
    out_res_d   = out_res_q;
    out_end_d   = out_end_q;
    out_last_d  = out_last_q;
    out_trunc_d = out_trunc_q;
    out_drop_d  = out_drop_q;

    tgt_we = 1'b0; tgt_re = 1'b0; tgt_waddr = '0; tgt_raddr = '0; tgt_wdata = '0;
    nxt_we = 1'b0; nxt_re = 1'b0; nxt_waddr = '0; nxt_raddr = '0; nxt_wdata = '0;
    head_we = 1'b0; head_re = 1'b0; head_waddr = '0; head_raddr = '0;
    head_wdata = '0;
    tail_we = 1'b0; tail_re = 1'b0; tail_waddr = '0; tail_raddr = '0;
    tail_wdata = '0;
    par_we = 1'b0; par_re = 1'b0; par_waddr = '0; par_raddr = '0; par_wdata = '0;
    stk_we = 1'b0; stk_re = 1'b0; stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;
    buf_we = 1'b0; buf_re = 1'b0; buf_waddr = '0; buf_raddr = '0; buf_wdata = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            dcf_pkg::CMD_ADD: begin
              if (used_q >= LW'(MAX_EDGES)) begin
                drop_d = 1'b1;
              end else begin
                // new entry ends its list; the tail ram is read before update
                tgt_we     = 1'b1;
                tgt_waddr  = used_q[EW-1:0];
                tgt_wdata  = to_vertex_i;
                nxt_we     = 1'b1;
                nxt_waddr  = used_q[EW-1:0];
                nxt_wdata  = NULL_LINK;
                tail_we    = 1'b1;
                tail_waddr = from_vertex_i;
                tail_wdata = used_q;
                used_d     = used_q + 1'b1;
                if (hvalid_q[from_vertex_i]) begin
                  tail_re    = 1'b1;
                  tail_raddr = from_vertex_i;
                  idx_d      = used_q;
                  state_d    = S_ADD2;
                end else begin
                  head_we    = 1'b1;
                  head_waddr = from_vertex_i;
                  head_wdata = used_q;
                  hvalid_d[from_vertex_i] = 1'b1;
                end
              end
            end
            dcf_pkg::CMD_RUN: begin
              visited_d  = '0;
              on_path_d  = '0;
              root_d     = '0;
              emit_cnt_d = '0;
              trunc_d    = 1'b0;
              pend_v_d   = 1'b0;
              state_d    = S_ROOT;
            end
            dcf_pkg::CMD_CLEAR: begin
              hvalid_d = '0;
              used_d   = '0;
              drop_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD2: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_rdata[EW-1:0];
        nxt_wdata = idx_q;
        state_d   = S_IDLE;
      end
      S_ROOT: begin
        if (root_q >= lim) begin
          state_d = S_FIN;
        end else if (visited_q[root_q[VW-1:0]]) begin
          root_d = root_q + 1'b1;
        end else begin
          visited_d[root_q[VW-1:0]] = 1'b1;
          on_path_d[root_q[VW-1:0]] = 1'b1;
          top_v_d    = root_q[VW-1:0];
          sp_d       = dcf_pkg::SPW'(1);
          head_re    = 1'b1;
          head_raddr = root_q[VW-1:0];
          hv_rd_d    = hvalid_q[root_q[VW-1:0]];
          state_d    = S_HEAD;
        end
      end
      S_HEAD: begin
        top_e_d = hv_rd_q ? head_rdata : NULL_LINK;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (top_e_q == NULL_LINK) begin
          // adjacency exhausted: leave the path and pop
          on_path_d[top_v_q] = 1'b0;
          sp_d = sp_m1;
          if (sp_q == dcf_pkg::SPW'(1)) begin
            root_d  = root_q + 1'b1;
            state_d = S_ROOT;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = sp_m2[VW-1:0];
            state_d   = S_POP;
          end
        end else begin
          tgt_re    = 1'b1;
          tgt_raddr = top_e_q[EW-1:0];
          nxt_re    = 1'b1;
          nxt_raddr = top_e_q[EW-1:0];
          state_d   = S_EDGE;
        end
      end
      S_POP: begin
        top_v_d = stk_rdata[SW-1:LW];
        top_e_d = stk_rdata[LW-1:0];
        state_d = S_STEP;
      end
      S_EDGE: begin
        top_e_d = nxt_rdata;
        if ({1'b0, w} >= lim) begin
          state_d = S_STEP;
        end else if (!visited_q[w]) begin
          // descend: park the current top with its next edge
          par_we       = 1'b1;
          par_waddr    = w;
          par_wdata    = top_v_q;
          visited_d[w] = 1'b1;
          on_path_d[w] = 1'b1;
          stk_we       = 1'b1;
          stk_waddr    = sp_m1[VW-1:0];
          stk_wdata    = {top_v_q, nxt_rdata};
          sp_d         = sp_q + 1'b1;
          top_v_d      = w;
          head_re      = 1'b1;
          head_raddr   = w;
          hv_rd_d      = hvalid_q[w];
          state_d      = S_HEAD;
        end else if (on_path_q[w]) begin
          // back edge: collect v, parent(v), ... up to w
          cyc_w_d   = w;
          buf_we    = 1'b1;
          buf_waddr = '0;
          buf_wdata = top_v_q;
          n_d       = dcf_pkg::SPW'(1);
          if (top_v_q == w) begin
            state_d = S_ERD;
          end else begin
            par_re    = 1'b1;
            par_raddr = top_v_q;
            state_d   = S_WALK;
          end
        end else begin
          state_d = S_STEP;
        end
      end
      S_WALK: begin
        buf_we    = 1'b1;
        buf_waddr = n_q[VW-1:0];
        buf_wdata = par_rdata;
        n_d       = n_q + 1'b1;
        if (par_rdata == cyc_w_q) begin
          state_d = S_ERD;
        end else begin
          par_re    = 1'b1;
          par_raddr = par_rdata;
        end
      end
      S_ERD: begin
        buf_re    = 1'b1;
        buf_raddr = n_m1[VW-1:0];
        n_d       = n_m1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (emit_cnt_q >= OW'(OUT_LIMIT)) begin
          trunc_d = 1'b1;
          state_d = S_FIN;
        end else if (slot_free) begin
          if (pend_v_q) begin
            out_valid_d = 1'b1;
            out_vtx_d   = pend_vtx_q;
            out_res_d   = 1'b1;
            out_end_d   = pend_end_q;
            out_last_d  = 1'b0;
            out_trunc_d = 1'b0;
            out_drop_d  = drop_q;
          end
          pend_v_d   = 1'b1;
          pend_vtx_d = buf_rdata;
          pend_end_d = (n_q == '0);
          emit_cnt_d = emit_cnt_q + 1'b1;
          state_d    = (n_q == '0) ? S_STEP : S_ERD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_drop_d  = drop_q;
          if (emit_cnt_q == '0) begin
            out_vtx_d   = '0;
            out_res_d   = 1'b0;
            out_end_d   = 1'b0;
            out_trunc_d = 1'b0;
          end else begin
            out_vtx_d   = pend_vtx_q;
            out_res_d   = 1'b1;
            out_end_d   = pend_end_q;
            out_trunc_d = trunc_q;
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= dcf_pkg::VC_RESET;
      used_q      <= '0;
      drop_q      <= 1'b0;
      hvalid_q    <= '0;
      visited_q   <= '0;
      on_path_q   <= '0;
      root_q      <= '0;
      sp_q        <= '0;
      n_q         <= '0;
      emit_cnt_q  <= '0;
      trunc_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
      used_q      <= used_d;
      drop_q      <= drop_d;
      hvalid_q    <= hvalid_d;
      visited_q   <= visited_d;
      on_path_q   <= on_path_d;
      root_q      <= root_d;
      sp_q        <= sp_d;
      n_q         <= n_d;
      emit_cnt_q  <= emit_cnt_d;
      trunc_q     <= trunc_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hv_rd_q     <= hv_rd_d;
    idx_q       <= idx_d;
    top_v_q     <= top_v_d;
    top_e_q     <= top_e_d;
    cyc_w_q     <= cyc_w_d;
    pend_vtx_q  <= pend_vtx_d;
    pend_end_q  <= pend_end_d;
    out_vtx_q   <= out_vtx_d;
    out_res_q   <= out_res_d;
    out_end_q   <= out_end_d;
    out_last_q  <= out_last_d;
    out_trunc_q <= out_trunc_d;
    out_drop_q  <= out_drop_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign vertex_o        = out_vtx_q;
  assign valid_res_o     = out_res_q;
  assign cycle_end_o     = out_end_q;
  assign last_o          = out_last_q;
  assign truncated_o     = out_trunc_q;
  assign edges_dropped_o = out_drop_q;

  // checks
  `DCF_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= dcf_pkg::SPW'(NV), "stack pointer past vertex count")
  `DCF_ASSERT_IMP(a_emit_bound, 1'b1, emit_cnt_q <= OW'(OUT_LIMIT), "emitted count past cap")
  `DCF_ASSERT_IMP(a_pend_cnt, pend_v_q, emit_cnt_q != '0, "pending result without count")
  `DCF_ASSERT_NXT(a_run_start, (state_q == S_IDLE) && in_valid_i && (cmd_i == dcf_pkg::CMD_RUN), (state_q == S_ROOT) && (emit_cnt_q == '0), "run did not start")

endmodule

### src/dcf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dcf_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/dcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_checker
// watches the item, result and register ports of the directed cycle finder,
// keeps its own copy of the edge lists, predicts every run and compares
// ----------------------------------------------------------------------------
module dcf_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [dcf_pkg::VCW-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic [dcf_pkg::CW-1:0]  cmd_i,
  input  logic [dcf_pkg::VW-1:0]  from_vertex_i,
  input  logic [dcf_pkg::VW-1:0]  to_vertex_i,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [dcf_pkg::VW-1:0]  vertex_o,
  input  logic                    valid_res_o,
  input  logic                    cycle_end_o,
  input  logic                    last_o,
  input  logic                    truncated_o,
  input  logic                    edges_dropped_o,
  output int                      errors,
  output int                      pending
);

  localparam int EDGE_CAP = 256;
  localparam int CAP_OUT  = 64;
  localparam int NVX      = int'(dcf_pkg::NV);
  localparam logic [8:0] NIL = 9'd256;

  typedef struct packed {
    logic [dcf_pkg::VW-1:0] vertex;
    logic                   valid_res;
    logic                   cycle_end;
    logic                   last;
    logic                   truncated;
    logic                   dropped;
  } cycle_out_t;

  cycle_out_t expected_q[$];

  logic [dcf_pkg::VW-1:0]  edge_to   [EDGE_CAP];
  logic [8:0]              edge_link [EDGE_CAP];
  logic [8:0]              head      [NVX];
  logic [8:0]              tail      [NVX];
  logic [8:0]              n_edges;
  logic                    dropped;
  logic [dcf_pkg::VCW-1:0] vcount;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_expected(input cycle_out_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic wipe_lists();
    for (int i = 0; i < NVX; i++) begin
      head[i] = NIL;
      tail[i] = NIL;
    end
    n_edges = '0;
    dropped = 1'b0;
  endtask

  task automatic find_cycles();
    logic                   seen [NVX];
    logic                   on_walk [NVX];
    logic [dcf_pkg::VW-1:0] up [NVX];
    logic [dcf_pkg::VW-1:0] st_v [NVX];
    logic [8:0]             st_e [NVX];
    logic [dcf_pkg::VW-1:0] chain [NVX];
    cycle_out_t             res [CAP_OUT];
    int                     lim, sp, n, cnt;
    logic                   cut;
    logic [dcf_pkg::VW-1:0] v, w, cur;
    logic [8:0]             e;
    lim = (vcount > dcf_pkg::VC_MAX) ? NVX : int'(vcount);
    cnt = 0;
    cut = 1'b0;
    for (int i = 0; i < NVX; i++) begin
      seen[i] = 1'b0;
      on_walk[i] = 1'b0;
    end
    for (int root = 0; root < lim && !cut; root++) begin
      if (seen[root]) continue;
      seen[root] = 1'b1;
      on_walk[root] = 1'b1;
      st_v[0] = root[dcf_pkg::VW-1:0];
      st_e[0] = head[root];
      sp = 1;
      while (sp > 0 && !cut) begin
        v = st_v[sp-1];
        e = st_e[sp-1];
        if (e >= NIL) begin
          on_walk[v] = 1'b0;
          sp--;
          continue;
        end
        st_e[sp-1] = edge_link[e];
        w = edge_to[e];
        if (int'(w) >= lim) continue;
        if (!seen[w]) begin
          if (sp >= NVX) continue;
          up[w] = v;
          seen[w] = 1'b1;
          on_walk[w] = 1'b1;
          st_v[sp] = w;
          st_e[sp] = head[w];
          sp++;
        end else if (on_walk[w]) begin
          // collect the path back to the target, then emit from the target
          n = 0;
          cur = v;
          chain[n++] = cur;
          while (cur != w && n < NVX) begin
            cur = up[cur];
            chain[n++] = cur;
          end
          while (n > 0) begin
            n--;
            if (cnt >= CAP_OUT) begin
              cut = 1'b1;
              break;
            end
            res[cnt] = '{chain[n], 1'b1, (n == 0), 1'b0, 1'b0, dropped};
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) begin
      add_expected('{'0, 1'b0, 1'b0, 1'b1, 1'b0, dropped});
    end else begin
      res[cnt-1].last = 1'b1;
      res[cnt-1].truncated = cut;
      for (int i = 0; i < cnt; i++) add_expected(res[i]);
    end
  endtask

  task automatic apply_item(input logic [dcf_pkg::CW-1:0] c,
                            input logic [dcf_pkg::VW-1:0] f,
                            input logic [dcf_pkg::VW-1:0] t);
    logic [8:0] idx;
    case (c)
      dcf_pkg::CMD_ADD: begin
        if (n_edges >= EDGE_CAP) begin
          dropped = 1'b1;
        end else begin
          idx = n_edges;
          n_edges++;
          edge_to[idx] = t;
          edge_link[idx] = NIL;
          if (head[f] >= NIL) head[f] = idx;
          else edge_link[tail[f]] = idx;
          tail[f] = idx;
        end
      end
      dcf_pkg::CMD_RUN:   find_cycles();
      dcf_pkg::CMD_CLEAR: wipe_lists();
      default: ;
    endcase
  endtask

  task automatic check_result();
    cycle_out_t exp_r;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result vertex %0d", vertex_o));
      return;
    end
    exp_r = expected_q.pop_front();
    if (vertex_o !== exp_r.vertex)
      report_mismatch($sformatf("vertex %0d, want %0d", vertex_o, exp_r.vertex));
    if (valid_res_o !== exp_r.valid_res)
      report_mismatch($sformatf("valid_res %b, want %b", valid_res_o, exp_r.valid_res));
    if (cycle_end_o !== exp_r.cycle_end)
      report_mismatch($sformatf("cycle_end %b, want %b", cycle_end_o, exp_r.cycle_end));
    if (last_o !== exp_r.last)
      report_mismatch($sformatf("last %b, want %b", last_o, exp_r.last));
    if (truncated_o !== exp_r.truncated)
      report_mismatch($sformatf("truncated %b, want %b", truncated_o, exp_r.truncated));
    if (edges_dropped_o !== exp_r.dropped)
      report_mismatch($sformatf("edges_dropped %b, want %b", edges_dropped_o,
                                exp_r.dropped));
  endtask

  initial begin
    errors = 0;
    pending = 0;
    vcount = dcf_pkg::VC_RESET;
    wipe_lists();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount = dcf_pkg::VC_RESET;
      wipe_lists();
      expected_q.delete();
    end else begin
      if (cfg_we_i) vcount = cfg_data_i;
      if (in_valid_i && !in_stall_o) apply_item(cmd_i, from_vertex_i, to_vertex_i);
      if (out_valid_o && !out_stall_i) check_result();
    end
    pending = expected_q.size();
  end

endmodule

### verif/tb_directed_cycle_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directed_cycle_finder
// drives edge loads, clears and cycle searches into the directed cycle finder
// under several vertex counts and sender idle and receiver stall patterns; a checker beside the block
// predicts each run and compares every result item
// ----------------------------------------------------------------------------
module tb_directed_cycle_finder;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;     // an add can still be relinking after the last result
  localparam int ITEM_TARGET = 380;
  localparam logic [dcf_pkg::CW-1:0] CMD_UNKNOWN = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [dcf_pkg::VCW-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [dcf_pkg::CW-1:0]  cmd_i = dcf_pkg::CMD_ADD;
  logic [dcf_pkg::VW-1:0]  from_vertex_i = '0;
  logic [dcf_pkg::VW-1:0]  to_vertex_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [dcf_pkg::VW-1:0]  vertex_o;
  logic                    valid_res_o;
  logic                    cycle_end_o;
  logic                    last_o;
  logic                    truncated_o;
  logic                    edges_dropped_o;

  int errors;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int send_idle_pct = 0;   // chance in a hundred, on each draw, that the sender idles
  int recv_stall_pct = 0;  // chance in a hundred, on each clock, that the receiver stalls

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  directed_cycle_finder u_top (.*);

  dcf_checker u_checker (.*);

  // receiver stalls at random, independent of what the block shows
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one item through the input channel, with optional idle cycles first
  task automatic send_item(input logic [dcf_pkg::CW-1:0] c,
                           input logic [dcf_pkg::VW-1:0] f,
                           input logic [dcf_pkg::VW-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    from_vertex_i <= f;
    to_vertex_i   <= t;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) break;
    end
    items_sent++;
  endtask

  // let all results drain, then give the engine time to go quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    // let the checker log the last accepted item first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_vcount(input logic [dcf_pkg::VCW-1:0] v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  initial begin
    int seg;
    int k;
    int hi;
    logic [dcf_pkg::VCW-1:0] vc_now;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty graph gives the no-cycle item
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);
    // self loop on vertex zero
    send_item(dcf_pkg::CMD_ADD, 6'd0, 6'd0);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);
    // triangle, a back edge inside it, a self loop on the top vertex and a two-vertex cycle
    send_item(dcf_pkg::CMD_ADD, 6'd0, 6'd1);
    send_item(dcf_pkg::CMD_ADD, 6'd1, 6'd2);
    send_item(dcf_pkg::CMD_ADD, 6'd2, 6'd0);
    send_item(dcf_pkg::CMD_ADD, 6'd2, 6'd1);
    send_item(dcf_pkg::CMD_ADD, 6'd63, 6'd63);
    send_item(dcf_pkg::CMD_ADD, 6'd63, 6'd0);
    send_item(dcf_pkg::CMD_ADD, 6'd42, 6'd21);
    send_item(dcf_pkg::CMD_ADD, 6'd21, 6'd42);
    // unknown command is ignored
    send_item(CMD_UNKNOWN, 6'd63, 6'd63);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);

    // fewer vertices: edges to vertices past the count are skipped
    write_vcount(7'd2);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);
    // zero vertices: nothing searched
    write_vcount(7'd0);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);
    // above the vertex slots: saturates
    write_vcount(7'd127);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);
    // clear empties the edge store and lists
    send_item(dcf_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);

    // store full: overfill, run (may truncate), then clear resets the drop flag
    write_vcount(7'd64);
    set_phase(3);
    for (int i = 0; i < 260; i++)
      send_item(dcf_pkg::CMD_ADD, dcf_pkg::VW'($urandom_range(0, 63)),
                dcf_pkg::VW'($urandom_range(0, 63)));
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);
    send_item(dcf_pkg::CMD_CLEAR, 6'd0, 6'd0);
    send_item(dcf_pkg::CMD_RUN, 6'd0, 6'd0);

    // random: clear, a handful of edges, run; some noise in between
    seg = 0;
    while (items_sent < ITEM_TARGET) begin
      if (seg % 3 == 0) begin
        case ($urandom_range(0, 4))
          0: vc_now = 7'd1;
          1: vc_now = 7'd64;
          2: vc_now = dcf_pkg::VCW'($urandom_range(65, 127));
          default: vc_now = dcf_pkg::VCW'($urandom_range(2, 12));
        endcase
        write_vcount(vc_now);
        set_phase(seg / 3);
      end
      hi = (vc_now > 7'd64) ? 63 : (vc_now == 0 ? 0 : int'(vc_now) - 1);
      if ($urandom_range(0, 3) != 0) hi = (hi < 63) ? hi + 1 : hi;  // reach past the count
      if ($urandom_range(0, 5) == 0) hi = 63;
      send_item(dcf_pkg::CMD_CLEAR, dcf_pkg::VW'($urandom_range(0, 63)),
                dcf_pkg::VW'($urandom_range(0, 63)));
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(CMD_UNKNOWN, dcf_pkg::VW'($urandom_range(0, 63)),
                    dcf_pkg::VW'($urandom_range(0, 63)));
        else
          send_item(dcf_pkg::CMD_ADD, dcf_pkg::VW'($urandom_range(0, hi)),
                    dcf_pkg::VW'($urandom_range(0, hi)));
      end
      send_item(dcf_pkg::CMD_RUN, dcf_pkg::VW'($urandom_range(0, 63)),
                dcf_pkg::VW'($urandom_range(0, 63)));
      seg++;
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
